>>> rtl/drg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drg_pkg: shared types and constants for the graph reachability core
// Vertex sizing, request opcodes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package drg_pkg;

   localparam int unsigned N_VERTICES = 32;
   localparam int unsigned VERTEX_W   = $clog2(N_VERTICES);

   typedef logic [N_VERTICES-1:0] vset_type;
   typedef logic [VERTEX_W-1:0]   vertex_type;
   typedef logic [1:0]            opcode_type;

   localparam opcode_type OP_CLEAR    = 2'd0;
   localparam opcode_type OP_ADD_EDGE = 2'd1;
   localparam opcode_type OP_QUERY    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE_RD,
      ST_EDGE_WR,
      ST_QINIT,
      ST_PICK,
      ST_MERGE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic clear_graph;
      logic edge_read;
      logic edge_write;
      logic query_init;
      logic pick;
      logic merge;
      logic rsp_push;
   } cmd_type;

   typedef struct packed {
      logic pending_empty;
      logic goal_found;
      logic rsp_busy;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/drg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drg_ctrl: sequencing controller
// Accepts one request at a time and steps the datapath through edge
// read-modify-write or the search loop of a query.
// ----------------------------------------------------------------------------
module drg_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire drg_pkg::opcode_type req_opcode,
   input  wire drg_pkg::status_type status,
   output drg_pkg::cmd_type       cmd
);
   import drg_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_ADD_EDGE: state_in = ST_EDGE_RD;
                  OP_QUERY:    state_in = ST_QINIT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_EDGE_RD: state_in = ST_EDGE_WR;
         ST_EDGE_WR: state_in = ST_IDLE;
         ST_QINIT:   state_in = ST_PICK;
         ST_PICK: begin
            if (status.goal_found || status.pending_empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE:   state_in = ST_PICK;
         ST_DONE: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_req    = accept;
            cmd.clear_graph = accept && (req_opcode == OP_CLEAR);
         end
         ST_EDGE_RD: cmd.edge_read  = 1'b1;
         ST_EDGE_WR: cmd.edge_write = 1'b1;
         ST_QINIT:   cmd.query_init = 1'b1;
         ST_PICK: begin
            cmd.pick = !(status.goal_found || status.pending_empty);
         end
         ST_MERGE:   cmd.merge    = 1'b1;
         ST_DONE:    cmd.rsp_push = !status.rsp_busy;
         default:    cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/drg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drg_datapath: adjacency storage and search registers
// Holds the adjacency rows in a single-port memory with per-row valid bits,
// the visited and pending vertex sets, and the response register.
// ----------------------------------------------------------------------------
module drg_datapath (
   input  wire                      clock,
   input  wire                      reset,
   input  wire drg_pkg::cmd_type    cmd,
   output drg_pkg::status_type      status,
   input  wire drg_pkg::vertex_type req_from_vertex,
   input  wire drg_pkg::vertex_type req_to_vertex,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic                     rsp_reachable
);
   import drg_pkg::*;

   vset_type   adj_mem [N_VERTICES];
   vset_type   row_valid_ff;
   vset_type   rd_row_ff;
   logic       rd_valid_ff;
   vset_type   row;
   vertex_type rd_addr;

   vertex_type from_ff;
   vertex_type to_ff;
   vset_type   visited_ff;
   vset_type   visited_in;
   vset_type   pending_ff;
   vset_type   pending_in;
   vertex_type pick_idx;
   vset_type   new_bits;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_reachable_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         from_ff <= req_from_vertex;
         to_ff   <= req_to_vertex;
      end
   end

   // Rows never written since the last clear read as empty.
   assign row     = rd_valid_ff ? rd_row_ff : '0;
   assign rd_addr = cmd.edge_read ? from_ff : pick_idx;

   always_ff @(posedge clock) begin
      if (cmd.edge_read || cmd.pick) begin
         rd_row_ff   <= adj_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
      if (cmd.edge_write) begin
         adj_mem[from_ff] <= row | (vset_type'(1) << to_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_graph) begin
         row_valid_ff <= '0;
      end else if (cmd.edge_write) begin
         row_valid_ff[from_ff] <= 1'b1;
      end
   end

   // Lowest pending vertex is expanded next.
   always_comb begin
      pick_idx = '0;
      for (int i = N_VERTICES - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            pick_idx = vertex_type'(i);
         end
      end
   end

   assign new_bits = row & ~visited_ff;

   always_comb begin
      visited_in = visited_ff;
      pending_in = pending_ff;
      if (cmd.clear_graph) begin
         visited_in = '0;
         pending_in = '0;
      end else if (cmd.query_init) begin
         visited_in = vset_type'(1) << from_ff;
         pending_in = vset_type'(1) << from_ff;
      end else if (cmd.pick) begin
         pending_in = pending_ff & ~(vset_type'(1) << pick_idx);
      end else if (cmd.merge) begin
         visited_in = visited_ff | new_bits;
         pending_in = pending_ff | new_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         pending_ff <= '0;
      end else begin
         visited_ff <= visited_in;
         pending_ff <= pending_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_push) begin
         rsp_reachable_ff <= visited_ff[to_ff];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_reachable        = rsp_reachable_ff;
   assign status.pending_empty = (pending_ff == '0);
   assign status.goal_found    = visited_ff[to_ff];
   assign status.rsp_busy      = rsp_valid_ff & ~rsp_ready;

`ifndef NO_ASSERTIONS
   a_pending_in_visited : assert property (@(posedge clock) disable iff (reset)
      (pending_ff & ~visited_ff) == '0)
      else $error("pending vertex not marked visited");

   a_pick_nonempty : assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> (pending_ff != '0))
      else $error("expansion issued with no pending vertex");

   a_merge_monotonic : assert property (@(posedge clock) disable iff (reset)
      cmd.merge |=> ((visited_ff & $past(visited_ff)) == $past(visited_ff)))
      else $error("visited set lost a vertex during merge");

   a_edge_row_valid : assert property (@(posedge clock) disable iff (reset)
      cmd.edge_write |=> row_valid_ff[$past(from_ff)])
      else $error("written adjacency row not marked valid");

   a_push_slot_free : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_push |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response pushed over an untaken response");
`endif

endmodule
`default_nettype wire

>>> rtl/directed_graph_reachability_core.sv
`default_nettype none
// A clear request is done on acceptance, an add-edge request reads the row and then
// writes it back, and a query seeds the search and then expands one pending vertex
// at a time, each expansion a pick state that reads the single-port adjacency memory
// and a merge state. The search ends early once the goal is reached; the answer is
// registered and a held response stalls the core. One request is in work at a time.
// Reset (synchronous) clears the row valid bits at once, so no sweep runs.
// ----------------------------------------------------------------------------
// directed_graph_reachability_core: graph reachability engine
// Stores directed edges as adjacency rows and answers reachability queries
// by expanding a visited set one vertex at a time.
// ----------------------------------------------------------------------------
module directed_graph_reachability_core (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire drg_pkg::opcode_type req_opcode,
   input  wire drg_pkg::vertex_type req_from_vertex,
   input  wire drg_pkg::vertex_type req_to_vertex,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic                     rsp_reachable
);
   import drg_pkg::*;

   cmd_type    cmd;
   status_type status;

   drg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   drg_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reachable   (rsp_reachable)
   );

endmodule
`default_nettype wire

>>> test/directed_graph_reachability_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// directed_graph_reachability_core_tb: self-checking bench for the core
// A short table of directed requests, then random graph episodes (random
// edge sets, long vertex chains, noise). Each reachability answer is checked
// against a behavioral adjacency-matrix search or a fixed table answer, with
// random idle bursts on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module directed_graph_reachability_core_tb;
   import drg_pkg::*;

   localparam opcode_type OP_UNUSED  = 2'd3;
   localparam int         ITEM_GOAL  = 1850;
   localparam int         CALM_TAIL  = 150;
   localparam int         LONG_HOLD  = 400;
   localparam int         DRAIN_WAIT = 80;

   typedef struct packed {
      opcode_type op;
      vertex_type src;
      vertex_type dst;
      logic       fixed;
      logic       fixed_ans;
   } stim_row_type;

   typedef struct packed {
      vertex_type src;
      vertex_type dst;
      logic       reachable;
   } answer_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   opcode_type req_opcode = OP_CLEAR;
   vertex_type req_from_vertex = '0;
   vertex_type req_to_vertex = '0;
   logic       req_fixed = 1'b0;
   logic       req_fixed_ans = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_reachable;

   // Behavioral copy of the graph state.
   vset_type   graph_rows [N_VERTICES];
   vset_type   seen_set = '0;
   vset_type   wave_set = '0;

   answer_type answers_due [$];
   int         error_count = 0;
   int         sent_count = 0;
   bit         idle_on = 1'b1;
   int         gap_pct = 25;
   bit         hold_rsp = 1'b0;

   directed_graph_reachability_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reachable   (rsp_reachable)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < N_VERTICES; i++) graph_rows[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #12_000_000;
      $display("simulation failed");
      $finish;
   end

   // Applies one request to the behavioral graph and returns its answer, if any.
   task automatic apply_graph_request(input opcode_type op, input vertex_type src,
                                      input vertex_type dst, output bit has_ans,
                                      output bit ans);
      vset_type grow;
      has_ans = 1'b0;
      ans     = 1'b0;
      case (op)
         OP_CLEAR: begin
            for (int i = 0; i < N_VERTICES; i++) graph_rows[i] = '0;
            seen_set = '0;
            wave_set = '0;
         end
         OP_ADD_EDGE: begin
            graph_rows[src][dst] = 1'b1;
         end
         OP_QUERY: begin
            has_ans = 1'b1;
            if (src == dst) begin
               ans = 1'b1;
            end else begin
               seen_set      = '0;
               seen_set[src] = 1'b1;
               wave_set      = seen_set;
               for (int r = 0; r < N_VERTICES && wave_set != '0; r++) begin
                  grow = '0;
                  for (int v = 0; v < N_VERTICES; v++)
                     if (wave_set[v]) grow |= graph_rows[v];
                  grow &= ~seen_set;
                  seen_set |= grow;
                  wave_set = grow;
               end
               ans = seen_set[dst];
            end
         end
         default: ;
      endcase
   endtask

   // Response check first, then the prediction for a request taken at this edge.
   always @(posedge clock) begin
      bit         has_ans;
      bit         ans;
      answer_type due;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               error_count++;
               $display("%0t: response with no query waiting: expected none, actual %0d",
                        $time, rsp_reachable);
            end else begin
               due = answers_due.pop_front();
               if (rsp_reachable !== due.reachable) begin
                  error_count++;
                  $display("%0t: reachable %0d->%0d: expected %0d, actual %0d", $time,
                           due.src, due.dst, due.reachable, rsp_reachable);
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_graph_request(req_opcode, req_from_vertex, req_to_vertex, has_ans, ans);
            if (has_ans) begin
               due.src       = req_from_vertex;
               due.dst       = req_to_vertex;
               due.reachable = req_fixed ? req_fixed_ans : ans;
               answers_due.push_back(due);
            end
         end
      end
   end

   // Result side: ready stretches broken by stall bursts, plus one long hold-off.
   initial begin
      int n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         n = $urandom_range(1, 20);
         repeat (n) @(posedge clock);
      end
   end

   task automatic send_req(input opcode_type op, input vertex_type src, input vertex_type dst,
                           input bit fixed = 1'b0, input bit fixed_ans = 1'b0);
      int gap;
      if (idle_on && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_from_vertex <= src;
      req_to_vertex   <= dst;
      req_fixed       <= fixed;
      req_fixed_ans   <= fixed_ans;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op != OP_UNUSED) sent_count++;
   endtask

   function automatic vertex_type rand_vertex(input int base, input int span);
      return vertex_type'(base + $urandom_range(0, span - 1));
   endfunction

   initial begin
      stim_row_type dir_table [0:23];
      int           perm [N_VERTICES];
      int           base, span, count, len, j, tmp, kind;
      vertex_type   a, b;

      dir_table = '{
         '{OP_QUERY,    5'd0,  5'd31, 1'b1, 1'b0},  // empty graph after reset
         '{OP_QUERY,    5'd31, 5'd31, 1'b1, 1'b1},
         '{OP_QUERY,    5'd0,  5'd0,  1'b1, 1'b1},
         '{OP_ADD_EDGE, 5'd0,  5'd31, 1'b0, 1'b0},
         '{OP_QUERY,    5'd0,  5'd31, 1'b1, 1'b1},
         '{OP_QUERY,    5'd31, 5'd0,  1'b1, 1'b0},
         '{OP_ADD_EDGE, 5'd31, 5'd31, 1'b0, 1'b0},  // self loop
         '{OP_QUERY,    5'd31, 5'd30, 1'b1, 1'b0},
         '{OP_ADD_EDGE, 5'd0,  5'd31, 1'b0, 1'b0},  // repeated edge
         '{OP_ADD_EDGE, 5'd31, 5'd16, 1'b0, 1'b0},
         '{OP_ADD_EDGE, 5'd16, 5'd0,  1'b0, 1'b0},  // closes a cycle
         '{OP_QUERY,    5'd16, 5'd31, 1'b0, 1'b0},
         '{OP_QUERY,    5'd0,  5'd5,  1'b0, 1'b0},
         '{OP_UNUSED,   5'd31, 5'd31, 1'b0, 1'b0},
         '{OP_QUERY,    5'd0,  5'd16, 1'b0, 1'b0},
         '{OP_CLEAR,    5'd31, 5'd31, 1'b0, 1'b0},
         '{OP_QUERY,    5'd0,  5'd31, 1'b1, 1'b0},
         '{OP_ADD_EDGE, 5'd21, 5'd10, 1'b0, 1'b0},
         '{OP_ADD_EDGE, 5'd10, 5'd21, 1'b0, 1'b0},
         '{OP_QUERY,    5'd10, 5'd21, 1'b0, 1'b0},
         '{OP_UNUSED,   5'd0,  5'd0,  1'b0, 1'b0},
         '{OP_QUERY,    5'd21, 5'd10, 1'b0, 1'b0},
         '{OP_CLEAR,    5'd0,  5'd0,  1'b0, 1'b0},
         '{OP_QUERY,    5'd21, 5'd10, 1'b1, 1'b0}
      };

      while (reset) @(posedge clock);

      foreach (dir_table[i])
         send_req(dir_table[i].op, dir_table[i].src, dir_table[i].dst,
                  dir_table[i].fixed, dir_table[i].fixed_ans);

      // Back-to-back queries against a held-off result channel fill the core.
      gap_pct = 0;
      send_req(OP_CLEAR, 5'd0, 5'd0);
      for (int i = 0; i < 6; i++) send_req(OP_ADD_EDGE, vertex_type'(i), vertex_type'(i + 1));
      hold_rsp = 1'b1;
      for (int i = 0; i < 12; i++) send_req(OP_QUERY, rand_vertex(0, 8), rand_vertex(0, 8));

      while (sent_count < ITEM_GOAL) begin
         if (sent_count >= ITEM_GOAL - CALM_TAIL) idle_on = 1'b0;
         gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            // Random edge set inside a vertex window, then queries.
            span = $urandom_range(2, N_VERTICES);
            base = $urandom_range(0, N_VERTICES - span);
            if ($urandom_range(0, 7) != 0) send_req(OP_CLEAR, rand_vertex(0, 32),
                                                    rand_vertex(0, 32));
            count = $urandom_range(0, 2 * span);
            for (int i = 0; i < count; i++) begin
               if ($urandom_range(0, 19) == 0)
                  send_req(OP_UNUSED, rand_vertex(0, 32), rand_vertex(0, 32));
               send_req(OP_ADD_EDGE, rand_vertex(base, span), rand_vertex(base, span));
            end
            count = $urandom_range(4, 16);
            for (int i = 0; i < count; i++) begin
               a = rand_vertex(base, span);
               b = rand_vertex(base, span);
               case ($urandom_range(0, 9))
                  0:       b = a;
                  1:       b = rand_vertex(0, 32);
                  default: ;
               endcase
               send_req(OP_QUERY, a, b);
            end
         end else if (kind <= 7) begin
            // A path through a shuffled vertex order, sometimes closed into a loop.
            for (int i = 0; i < N_VERTICES; i++) perm[i] = i;
            for (int i = N_VERTICES - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = perm[i];
               perm[i] = perm[j];
               perm[j] = tmp;
            end
            len = ($urandom_range(0, 3) == 0) ? N_VERTICES - 1 : $urandom_range(1, 31);
            send_req(OP_CLEAR, rand_vertex(0, 32), rand_vertex(0, 32));
            for (int i = 0; i < len; i++)
               send_req(OP_ADD_EDGE, vertex_type'(perm[i]), vertex_type'(perm[i + 1]));
            if ($urandom_range(0, 1) == 0)
               send_req(OP_ADD_EDGE, vertex_type'(perm[len]),
                        vertex_type'(perm[$urandom_range(0, len)]));
            send_req(OP_QUERY, vertex_type'(perm[0]), vertex_type'(perm[len]));
            send_req(OP_QUERY, vertex_type'(perm[len]), vertex_type'(perm[0]));
            for (int i = 0; i < 6; i++)
               send_req(OP_QUERY, vertex_type'(perm[$urandom_range(0, 31)]),
                        vertex_type'(perm[$urandom_range(0, 31)]));
         end else begin
            count = $urandom_range(8, 12);
            for (int i = 0; i < count; i++)
               send_req(opcode_type'($urandom_range(0, 3)), rand_vertex(0, 32),
                        rand_vertex(0, 32));
         end
      end

      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0 && answers_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
